// ----- src/pcps_pkg.sv -----
`timescale 1ns / 1ps
package pcps_pkg;

  localparam int unsigned DEF_MAX_ATOMS = 256;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned CHARGE_W = 16;
  localparam int unsigned POT_W    = 48;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned ATOM_W   = 3 * COORD_W + CHARGE_W;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

endpackage

// ----- src/pcps_ram.sv -----
`timescale 1ns / 1ps
module pcps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/point_charge_potential_sum.sv -----
`timescale 1ns / 1ps
// Channel | Signals                                   | Handshake
// --------+-------------------------------------------+-------------------------
// in      | cmd, atom_index, pos_x/y/z, point_charge  | in_valid_i / in_ready_o
// out     | potential, saturated                      | out_valid_o / out_ready_i
// config  | cfg_wdata_i (atom_count)                  | cfg_we_i, no wait
//
// A load transaction writes one table slot.
// An evaluate transaction streams one atom per cycle from the atom RAM through a pipeline
// (difference, halving, squares, sum, 32-stage root, 48-stage divide); an empty sum finishes
// without reading the RAM. The RAM read port sets the pace.
// Reset clears the control state and the root and divider pipelines; the atom table is undefined until loaded.
// A stalled output holds the result; the next transaction is taken once it is registered.
module point_charge_potential_sum #(
  parameter int unsigned MAX_ATOMS = pcps_pkg::DEF_MAX_ATOMS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcps_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [pcps_pkg::IDX_W-1:0]      atom_index_i,
  input  logic signed [pcps_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [pcps_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [pcps_pkg::COORD_W-1:0]  pos_z_i,
  input  logic signed [pcps_pkg::CHARGE_W-1:0] point_charge_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [pcps_pkg::POT_W-1:0] potential_o,
  output logic                            saturated_o
);

  import pcps_pkg::*;

  localparam int unsigned AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW    = $clog2(MAX_ATOMS + 1);
  localparam int unsigned ACC_W = 2 * CHARGE_W + 17 + CW;
  localparam int unsigned SQ_N  = 32;
  localparam int unsigned DV_N  = 48;

  localparam logic signed [ACC_W-1:0] ACC_MAX =
      ACC_W'({1'b0, {(POT_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_MIN =
      -ACC_W'({1'b0, {(POT_W-1){1'b1}}}) - ACC_W'(1);

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
    logic [15:0] q;
    logic        big;
    logic        v;
    logic        last;
  } sq_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [47:0] num;
    logic [47:0] quo;
    logic [32:0] den;
    logic        neg;
    logic        pin;
    logic        v;
    logic        last;
  } dv_t;

  // ---------------------------------------------------------------- control
  logic [CNT_W-1:0]        count_q;
  logic                    busy_q, issuing_q, done_q;
  logic [CW-1:0]           idx_q, n_q, n_clamp;
  logic signed [31:0]      gx_q, gy_q, gz_q;
  logic                    in_acc, load_we, last_issue, xfer;
  logic [ATOM_W-1:0]       rdata;

  assign in_ready_o   = ~busy_q;
  assign in_acc       = in_valid_i & in_ready_o;
  assign load_we      = in_acc && (cmd_i == CMD_LOAD) &&
                        (int'(atom_index_i) < int'(MAX_ATOMS));
  assign n_clamp      = (int'(count_q) > int'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                                                         : CW'(count_q);
  assign last_issue   = (idx_q == n_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  pcps_ram #(
    .WIDTH (ATOM_W),
    .DEPTH (MAX_ATOMS),
    .AW    (AW)
  ) u_atom_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(atom_index_i)),
    .wdata_i ({pos_x_i, pos_y_i, pos_z_i, point_charge_i}),
    .re_i    (issuing_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------- front stages
  logic                rd_v_q, rd_last_q;
  logic [31:0]         mx_q, my_q, mz_q;
  logic [15:0]         q1_q, q2_q, q3_q, q4_q;
  logic                v1_q, l1_q, v2_q, l2_q, v3_q, l3_q, v4_q, l4_q;
  logic [30:0]         hx_q, hy_q, hz_q;
  logic                big2_q, big3_q, big4_q;
  logic [61:0]         sx_q, sy_q, sz_q;
  logic [63:0]         ssum_q;
  logic signed [32:0]  dx, dy, dz;
  logic                big;

  assign dx  = 33'(signed'(rdata[ATOM_W-1 -: 32])) - 33'(gx_q);
  assign dy  = 33'(signed'(rdata[ATOM_W-33 -: 32])) - 33'(gy_q);
  assign dz  = 33'(signed'(rdata[ATOM_W-65 -: 32])) - 33'(gz_q);
  assign big = mx_q[31] | my_q[31] | mz_q[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else begin
      rd_v_q <= issuing_q;
      v1_q   <= rd_v_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q <= issuing_q & last_issue;
    // absolute differences
    mx_q <= dx[32] ? 32'(-dx) : dx[31:0];
    my_q <= dy[32] ? 32'(-dy) : dy[31:0];
    mz_q <= dz[32] ? 32'(-dz) : dz[31:0];
    q1_q <= rdata[15:0];
    l1_q <= rd_last_q;
    // halve all axes when any exceeds 31 bits
    hx_q   <= big ? mx_q[31:1] : mx_q[30:0];
    hy_q   <= big ? my_q[31:1] : my_q[30:0];
    hz_q   <= big ? mz_q[31:1] : mz_q[30:0];
    big2_q <= big;
    q2_q   <= q1_q;
    l2_q   <= l1_q;
    // squares
    sx_q   <= 62'(hx_q) * 62'(hx_q);
    sy_q   <= 62'(hy_q) * 62'(hy_q);
    sz_q   <= 62'(hz_q) * 62'(hz_q);
    big3_q <= big2_q;
    q3_q   <= q2_q;
    l3_q   <= l2_q;
    // sum of squares
    ssum_q <= 64'(sx_q) + 64'(sy_q) + 64'(sz_q);
    big4_q <= big3_q;
    q4_q   <= q3_q;
    l4_q   <= l3_q;
  end

  // ---------------------------------------------------------------- root pipeline
  sq_t sq_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    sq_t         cur;
    logic [35:0] rem2, trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign cur = '{rem: '0, root: '0, rad: ssum_q, q: q4_q, big: big4_q,
                     v: v4_q, last: l4_q};
    end else begin : g_next
      assign cur = sq_q[k-1];
    end

    assign rem2  = {cur.rem[33:0], cur.rad[63:62]};
    assign trial = {2'b00, cur.root, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k] <= '0;
      end else begin
        sq_q[k].rem  <= ge ? (rem2 - trial) : rem2;
        sq_q[k].root <= {cur.root[30:0], ge};
        sq_q[k].rad  <= {cur.rad[61:0], 2'b00};
        sq_q[k].q    <= cur.q;
        sq_q[k].big  <= cur.big;
        sq_q[k].v    <= cur.v;
        sq_q[k].last <= cur.last;
      end
    end
  end

  // ---------------------------------------------------------------- divider pipeline
  dv_t         dv_in_q;
  dv_t         dv_q [DV_N];
  sq_t         sq_out;
  logic [32:0] distance;
  logic signed [15:0] qs;
  logic [15:0] qmag;

  assign sq_out   = sq_q[SQ_N-1];
  assign distance = sq_out.big ? {sq_out.root, 1'b0} : {1'b0, sq_out.root};
  assign qs       = signed'(sq_out.q);
  assign qmag     = qs[15] ? 16'(-qs) : sq_out.q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_in_q <= '0;
    end else begin
      dv_in_q.rem  <= '0;
      dv_in_q.num  <= {qmag, 32'd0};
      dv_in_q.quo  <= '0;
      // a zero charge must give a zero term, even at zero distance
      dv_in_q.den  <= (sq_out.q == '0) ? 33'd1 : distance;
      dv_in_q.neg  <= qs[15];
      dv_in_q.pin  <= (distance == '0) && (sq_out.q != '0);
      dv_in_q.v    <= sq_out.v;
      dv_in_q.last <= sq_out.last;
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    dv_t         cur;
    logic [34:0] rem2, den_x;
    logic        ge;

    if (k == 0) begin : g_first
      assign cur = dv_in_q;
    end else begin : g_next
      assign cur = dv_q[k-1];
    end

    assign rem2  = {cur.rem, cur.num[47]};
    assign den_x = {2'b00, cur.den};
    assign ge    = (rem2 >= den_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= '0;
      end else begin
        dv_q[k].rem  <= ge ? 34'(rem2 - den_x) : rem2[33:0];
        dv_q[k].num  <= {cur.num[46:0], 1'b0};
        dv_q[k].quo  <= {cur.quo[46:0], ge};
        dv_q[k].den  <= cur.den;
        dv_q[k].neg  <= cur.neg;
        dv_q[k].pin  <= cur.pin;
        dv_q[k].v    <= cur.v;
        dv_q[k].last <= cur.last;
      end
    end
  end

  // ---------------------------------------------------------------- accumulate
  dv_t                     fin;
  logic signed [ACC_W-1:0] acc_q, term;
  logic                    pinned_q, pin_neg_q;
  logic signed [ACC_W-1:0] res;
  logic                    res_sat;
  logic                    out_valid_q, sat_q;
  logic signed [POT_W-1:0] pot_q;

  assign fin  = dv_q[DV_N-1];
  assign term = fin.neg ? -signed'(ACC_W'(fin.quo)) : signed'(ACC_W'(fin.quo));

  always_comb begin
    res     = acc_q;
    res_sat = 1'b0;
    if (pinned_q) begin
      res     = pin_neg_q ? ACC_MIN : ACC_MAX;
      res_sat = 1'b1;
    end else if (acc_q > ACC_MAX) begin
      res     = ACC_MAX;
      res_sat = 1'b1;
    end else if (acc_q < ACC_MIN) begin
      res     = ACC_MIN;
      res_sat = 1'b1;
    end
  end

  assign xfer = done_q & (~out_valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issuing_q   <= 1'b0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      pinned_q    <= 1'b0;
      pin_neg_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // start an evaluate; an empty sum finishes at once
      if (in_acc && (cmd_i == CMD_EVAL)) begin
        busy_q   <= 1'b1;
        acc_q    <= '0;
        pinned_q <= 1'b0;
        idx_q    <= '0;
        n_q      <= n_clamp;
        if (n_clamp == '0) begin
          done_q <= 1'b1;
        end else begin
          issuing_q <= 1'b1;
        end
      end
      // advance the read address, one atom per cycle
      if (issuing_q) begin
        idx_q <= idx_q + CW'(1);
        if (last_issue) begin
          issuing_q <= 1'b0;
        end
      end
      // retire terms in order; a zero distance with a nonzero charge pins the sum
      if (fin.v) begin
        if (!pinned_q) begin
          if (fin.pin) begin
            pinned_q  <= 1'b1;
            pin_neg_q <= fin.neg;
          end else begin
            acc_q <= acc_q + term;
          end
        end
        if (fin.last) begin
          done_q <= 1'b1;
        end
      end
      // hand the result to the output register
      if (xfer) begin
        done_q      <= 1'b0;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gx_q <= pos_x_i;
      gy_q <= pos_y_i;
      gz_q <= pos_z_i;
    end
    if (xfer) begin
      pot_q <= res[POT_W-1:0];
      sat_q <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign potential_o = pot_q;
  assign saturated_o = sat_q;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import pcps_pkg::*;

  localparam int unsigned NUM_SLOTS = DEF_MAX_ATOMS;
  localparam int unsigned STALL_LIMIT = 4000;
  // Drain time covers the full pipeline depth, with margin.
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam longint POT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POT_LO = -64'sh0000_7FFF_FFFF_FFFF - 1;

  typedef struct {
    logic signed [POT_W-1:0] potential;
    logic                    saturated;
  } potential_t;

  // Scoreboard: mirrors the atom table and the count register, computes the
  // potential for every evaluate transaction and holds it until it comes out.
  class potential_scoreboard;
    logic signed [COORD_W-1:0]  atom_x[NUM_SLOTS];
    logic signed [COORD_W-1:0]  atom_y[NUM_SLOTS];
    logic signed [COORD_W-1:0]  atom_z[NUM_SLOTS];
    logic signed [CHARGE_W-1:0] atom_q[NUM_SLOTS];
    logic [CNT_W-1:0]           atom_count;
    potential_t                 pending[$];
    int unsigned                mismatches;

    function new();
      atom_count = '0;
      mismatches = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= n) r = t;
      end
      return r;
    endfunction

    function automatic longint unsigned distance(int i, logic signed [COORD_W-1:0] gx,
                                                 logic signed [COORD_W-1:0] gy,
                                                 logic signed [COORD_W-1:0] gz);
      longint dx, dy, dz;
      longint unsigned mx, my, mz, root;
      bit big;
      dx = longint'(atom_x[i]) - longint'(gx);
      dy = longint'(atom_y[i]) - longint'(gy);
      dz = longint'(atom_z[i]) - longint'(gz);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      mz = dz < 0 ? -dz : dz;
      // Halve all axes when one difference no longer fits 31 bits.
      big = (mx >= 64'd1 << 31) || (my >= 64'd1 << 31) || (mz >= 64'd1 << 31);
      if (big) begin
        mx = mx >> 1;
        my = my >> 1;
        mz = mz >> 1;
      end
      root = int_sqrt(mx * mx + my * my + mz * mz);
      return big ? root << 1 : root;
    endfunction

    function void note_transaction(logic c, logic [IDX_W-1:0] idx,
                                   logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                   logic signed [COORD_W-1:0] z, logic signed [CHARGE_W-1:0] q);
      int n;
      longint sum, qq;
      longint unsigned d, mag;
      bit sat, pinned;
      potential_t res;
      if (c == CMD_LOAD) begin
        atom_x[idx] = x;
        atom_y[idx] = y;
        atom_z[idx] = z;
        atom_q[idx] = q;
        return;
      end
      n = atom_count > NUM_SLOTS ? NUM_SLOTS : atom_count;
      sum = 0;
      sat = 0;
      pinned = 0;
      for (int i = 0; i < n; i++) begin
        qq = longint'(atom_q[i]);
        d = distance(i, x, y, z);
        if (pinned || qq == 0) continue;
        if (d == 0) begin
          // A charge on the grid point pins the sum to its sign's extreme.
          pinned = 1;
          sat = 1;
          sum = qq < 0 ? POT_LO : POT_HI;
          continue;
        end
        mag = qq < 0 ? -qq : qq;
        mag = (mag << 32) / d;
        sum = qq < 0 ? sum - longint'(mag) : sum + longint'(mag);
      end
      if (!pinned && sum > POT_HI) begin
        sum = POT_HI;
        sat = 1;
      end else if (!pinned && sum < POT_LO) begin
        sum = POT_LO;
        sat = 1;
      end
      res.potential = sum[POT_W-1:0];
      res.saturated = sat;
      pending = {pending, res};
    endfunction

    function void check_result(logic signed [POT_W-1:0] pot, logic sat);
      potential_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result potential=%h saturated=%b", $realtime, pot, sat);
        return;
      end
      exp_res = pending.pop_front();
      if (pot !== exp_res.potential || sat !== exp_res.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch potential exp=%h act=%h saturated exp=%b act=%b",
                   $realtime, exp_res.potential, pot, exp_res.saturated, sat);
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CNT_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       cmd_i;
  logic [IDX_W-1:0]           atom_index_i;
  logic signed [COORD_W-1:0]  pos_x_i;
  logic signed [COORD_W-1:0]  pos_y_i;
  logic signed [COORD_W-1:0]  pos_z_i;
  logic signed [CHARGE_W-1:0] point_charge_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [POT_W-1:0]    potential_o;
  logic                       saturated_o;

  potential_scoreboard sb;
  bit                  slot_loaded[NUM_SLOTS];
  bit                  calm_in;
  bit                  calm_out;
  int unsigned         idle_cycles;

  point_charge_potential_sum u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .atom_index_i  (atom_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .point_charge_i(point_charge_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .potential_o   (potential_o),
    .saturated_o   (saturated_o)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Send one transaction; hold valid and payload until accepted.
  task automatic send_item(logic c, logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                           logic signed [CHARGE_W-1:0] q);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i          <= c;
    atom_index_i   <= idx;
    pos_x_i        <= x;
    pos_y_i        <= y;
    pos_z_i        <= z;
    point_charge_i <= q;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_transaction(c, idx, x, y, z, q);
    if (c == CMD_LOAD) slot_loaded[idx] = 1'b1;
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.atom_count = value;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'sh7FFF_FFFF : -32'sh7FFF_FFFF - 1;
      default: return $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
    endcase
  endfunction

  function automatic logic signed [CHARGE_W-1:0] rand_charge();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return CHARGE_W'($urandom);
    endcase
  endfunction

  function automatic int active_slots();
    return sb.atom_count > NUM_SLOTS ? NUM_SLOTS : sb.atom_count;
  endfunction

  // Random phase: loads keep every summed slot written, evaluates sometimes aim at a loaded atom's position.
  task automatic random_phase(int unsigned items, bit pause_mid);
    int n, j, hole;
    logic signed [COORD_W-1:0] gx, gy, gz;
    n = active_slots();
    calm_in  = $urandom_range(0, 3) == 0;
    calm_out = $urandom_range(0, 3) == 0;
    for (int k = 0; k < items; k++) begin
      if (pause_mid && k == items / 2) drain();
      hole = -1;
      for (int i = n - 1; i >= 0; i--) if (!slot_loaded[i]) hole = i;
      if (hole >= 0) begin
        send_item(CMD_LOAD, IDX_W'(hole), rand_coord(), rand_coord(), rand_coord(),
                  rand_charge());
      end else if ($urandom_range(0, 99) < 45) begin
        j = ($urandom_range(0, 1) == 0 || n == 0) ? $urandom_range(0, NUM_SLOTS - 1)
                                                   : $urandom_range(0, n - 1);
        send_item(CMD_LOAD, IDX_W'(j), rand_coord(), rand_coord(), rand_coord(),
                  rand_charge());
      end else begin
        if (n > 0 && $urandom_range(0, 5) == 0) begin
          j  = $urandom_range(0, n - 1);
          gx = sb.atom_x[j];
          gy = sb.atom_y[j];
          gz = sb.atom_z[j];
        end else begin
          gx = rand_coord();
          gy = rand_coord();
          gz = rand_coord();
        end
        send_item(CMD_EVAL, IDX_W'($urandom), gx, gy, gz, CHARGE_W'($urandom));
      end
    end
  endtask

  // Result side: stall a random number of cycles before each result.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = calm_out ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(potential_o, saturated_o);
    end
  end

  initial begin
    int unsigned counts[12] = '{2, 1, 7, 16, 40, 256, 511, 0, 12, 300, 5, 3};
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    idle_cycles = 0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_LOAD;
    atom_index_i <= '0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    pos_z_i <= '0;
    point_charge_i <= '0;
    out_ready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty sum, then extremes of position and charge.
    send_item(CMD_EVAL, 8'hFF, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF - 1, '0, 16'sh8000);
    send_item(CMD_LOAD, 0, '0, '0, '0, 16'sh7FFF);
    send_item(CMD_LOAD, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh8000);
    send_item(CMD_LOAD, 2, -32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1, '0);
    send_item(CMD_LOAD, 3, '0, '0, 32'sd1, 16'sh7FFF);
    send_item(CMD_LOAD, 255, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 16'sh0100);
    write_count(1);
    // Grid point on the charge, one unit away, and across the full range.
    send_item(CMD_EVAL, '0, '0, '0, '0, '0);
    send_item(CMD_EVAL, '0, 32'sd1, '0, '0, '0);
    send_item(CMD_EVAL, '0, -32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1,
              -32'sh7FFF_FFFF - 1, '0);
    write_count(4);
    // Positive pin, zero charge at zero distance, negative pin, overflow.
    send_item(CMD_EVAL, '0, '0, '0, '0, '0);
    send_item(CMD_EVAL, '0, -32'sh7FFF_FFFF - 1, -32'sh7FFF_FFFF - 1,
              -32'sh7FFF_FFFF - 1, '0);
    send_item(CMD_EVAL, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
    send_item(CMD_EVAL, '0, '0, '0, 32'sd2, '0);
    send_item(CMD_LOAD, 3, '0, '0, 32'sd1, 16'sh8000);
    send_item(CMD_LOAD, 0, '0, '0, '0, 16'sh8000);
    send_item(CMD_EVAL, '0, '0, '0, 32'sd2, '0);

    foreach (counts[p]) begin
      write_count(counts[p]);
      random_phase(counts[p] >= 256 ? 40 : 110, p == 3);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pcps_pkg.sv
src/pcps_ram.sv
src/point_charge_potential_sum.sv
dv/testbench.sv
